### design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// shared widths, request codes, status codes and sequencer states of the
// page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int ADDR_W     = 56;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 16;
    localparam int CFG_IDX_W  = 2;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADDREF = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BAD   = 2'd2;
    localparam logic [STATUS_W-1:0] STS_OVF   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_LOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP  = 2'd2;

    localparam logic [ADDR_W-1:0] MEM_BASE_RST  = 56'h0000_0080_000000;
    localparam logic [ADDR_W-1:0] ALLOC_LOW_RST = 56'h0000_0080_000000;
    localparam logic [ADDR_W-1:0] PHYS_TOP_RST  = 56'h0000_0088_000000;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_ALLOC,
        S_LOW,
        S_TOP,
        S_BASE,
        S_RANGE,
        S_EXEC,
        S_RESP
    } t_pfa_state;

endpackage

### design/pfa_if.sv
// ----------------------------------------------------------------------------
// pfa request and response channels
// valid/ready channels carrying one allocator request or one response
// ----------------------------------------------------------------------------
interface pfa_req_if
    import pfa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] page_addr;

    modport source (output valid, output func, output page_addr, input ready);
    modport sink   (input valid, input func, input page_addr, output ready);
endinterface

interface pfa_rsp_if
    import pfa_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    result_addr;
    logic [CNT_OUT_W-1:0] new_count;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output result_addr, output new_count,
                    output status, input ready);
    modport sink   (input valid, input result_addr, input new_count,
                    input status, output ready);
endinterface

### design/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int AW     = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/page_frame_allocator_refcount_unit.sv
// sequence: allocate steps through S_POP, S_ALLOC (skipped when the stack is empty)
//   and S_RESP; free and add reference through S_LOW, S_TOP, S_BASE, S_RANGE,
//   S_EXEC and S_RESP; a bad address finishes sooner. requests: one at a time, a
//   new one taken only back in S_IDLE; S_RESP waits while the output is stalled
// reset: synchronous active low; the count memory is then cleared, one entry
//   per cycle, over all NUM_PAGES entries before the first request is taken
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_unit
// page frame allocator with a lifo free stack and per-page reference counts
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount_unit
    import pfa_pkg::*;
#(
    parameter int NUM_PAGES   = 32768,
    parameter int PAGE_SHIFT  = 12,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    // request and response channels
    pfa_req_if.sink              i_req,
    pfa_rsp_if.source            o_rsp
);

    localparam int IDX_W   = $clog2(NUM_PAGES);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
    // bytes covered by the managed page range, for the index bound check
    localparam logic [ADDR_W-1:0] PAGE_SPAN = ADDR_W'(NUM_PAGES) << PAGE_SHIFT;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // sequencer and request registers
    t_pfa_state r_state, n_state;
    logic [FUNC_W-1:0]      r_func, n_func;
    logic [ADDR_W-1:0]      r_addr, n_addr;
    logic [ADDR_W-1:0]      r_off, n_off;
    logic [DEPTH_W-1:0]     r_depth, n_depth;
    logic [IDX_W-1:0]       r_clr_addr, n_clr_addr;

    // result held until the output register is free
    logic [ADDR_W-1:0]      r_res_addr, n_res_addr;
    logic [CNT_OUT_W-1:0]   r_res_count, n_res_count;
    logic [STATUS_W-1:0]    r_res_status, n_res_status;

    // output register
    logic                   r_rsp_valid, n_rsp_valid;
    logic [ADDR_W-1:0]      r_rsp_addr, n_rsp_addr;
    logic [CNT_OUT_W-1:0]   r_rsp_count, n_rsp_count;
    logic [STATUS_W-1:0]    r_rsp_status, n_rsp_status;

    // configuration registers
    logic [ADDR_W-1:0]      r_mem_base;
    logic [ADDR_W-1:0]      r_alloc_low;
    logic [ADDR_W-1:0]      r_phys_top;

    // shared adder / subtractor
    logic [ADDR_W-1:0]      alu_a;
    logic [ADDR_W-1:0]      alu_b;
    logic                   alu_sub;
    logic [ADDR_W:0]        alu_sum;
    logic                   alu_borrow;

    // count memory port
    logic                   cnt_we;
    logic [IDX_W-1:0]       cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [IDX_W-1:0]       cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_rdata;

    // free stack memory port
    logic                   stk_we;
    logic [IDX_W-1:0]       stk_waddr;
    logic [IDX_W-1:0]       stk_wdata;
    logic [IDX_W-1:0]       stk_raddr;
    logic [IDX_W-1:0]       stk_rdata;

    logic                   slot_free;
    logic [IDX_W-1:0]       cur_idx;
    logic [COUNT_WIDTH-1:0] alu_cnt;

    // one 57-bit add/subtract, the top bit is the borrow on subtract
    assign alu_sum    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                                : ({1'b0, alu_a} + {1'b0, alu_b});
    assign alu_borrow = alu_sum[ADDR_W];
    assign alu_cnt    = alu_sum[COUNT_WIDTH-1:0];

    // page index of the checked address, valid once the range check passed
    assign cur_idx   = r_off[PAGE_SHIFT +: IDX_W];
    assign slot_free = !r_rsp_valid || o_rsp.ready;

    // reference counts, cleared by a sweep after reset
    pfa_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_PAGES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // free stack, entries are only read below the fill depth
    pfa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_PAGES)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // configuration writes are taken at any time, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_base  <= MEM_BASE_RST;
            r_alloc_low <= ALLOC_LOW_RST;
            r_phys_top  <= PHYS_TOP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MEM_BASE:  r_mem_base  <= i_cfg_data;
                CFG_ALLOC_LOW: r_alloc_low <= i_cfg_data;
                CFG_PHYS_TOP:  r_phys_top  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_depth     <= '0;
            r_clr_addr  <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_clr_addr  <= n_clr_addr;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_addr       <= n_addr;
        r_off        <= n_off;
        r_res_addr   <= n_res_addr;
        r_res_count  <= n_res_count;
        r_res_status <= n_res_status;
        r_rsp_addr   <= n_rsp_addr;
        r_rsp_count  <= n_rsp_count;
        r_rsp_status <= n_rsp_status;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_addr       = r_addr;
        n_off        = r_off;
        n_depth      = r_depth;
        n_clr_addr   = r_clr_addr;
        n_res_addr   = r_res_addr;
        n_res_count  = r_res_count;
        n_res_status = r_res_status;
        n_rsp_valid  = r_rsp_valid && !o_rsp.ready;
        n_rsp_addr   = r_rsp_addr;
        n_rsp_count  = r_rsp_count;
        n_rsp_status = r_rsp_status;

        i_req.ready  = 1'b0;

        alu_a        = r_addr;
        alu_b        = r_alloc_low;
        alu_sub      = 1'b1;

        cnt_we       = 1'b0;
        cnt_waddr    = cur_idx;
        cnt_wdata    = '0;
        cnt_raddr    = cur_idx;

        stk_we       = 1'b0;
        stk_waddr    = IDX_W'(r_depth);
        stk_wdata    = cur_idx;
        stk_raddr    = IDX_W'(r_depth - 1'b1);

        unique case (r_state)
            // zero every count after reset
            S_CLEAR: begin
                cnt_we     = 1'b1;
                cnt_waddr  = r_clr_addr;
                cnt_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == IDX_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_addr  = i_req.page_addr;
                    n_state = (i_req.func == FUNC_ALLOC) ? S_POP : S_LOW;
                end
            end

            // pop: read the top of the stack or report empty
            S_POP: begin
                if (r_depth == '0) begin
                    n_res_addr   = '0;
                    n_res_count  = '0;
                    n_res_status = STS_EMPTY;
                    n_state      = S_RESP;
                end else begin
                    n_depth = r_depth - 1'b1;
                    n_state = S_ALLOC;
                end
            end

            // page address = base + index * page size; count set to one
            S_ALLOC: begin
                alu_a        = r_mem_base;
                alu_b        = ADDR_W'(stk_rdata) << PAGE_SHIFT;
                alu_sub      = 1'b0;
                cnt_we       = 1'b1;
                cnt_waddr    = stk_rdata;
                cnt_wdata    = CNT_ONE;
                n_res_addr   = alu_sum[ADDR_W-1:0];
                n_res_count  = CNT_OUT_W'(CNT_ONE);
                n_res_status = STS_OK;
                n_state      = S_RESP;
            end

            // unused code, misalignment and lower bound
            S_LOW: begin
                n_res_addr   = r_addr;
                n_res_count  = '0;
                n_res_status = STS_BAD;
                if (r_func == FUNC_NONE || r_addr[PAGE_SHIFT-1:0] != '0
                    || alu_borrow) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_TOP;
                end
            end

            // must lie below the top of physical memory
            S_TOP: begin
                alu_b   = r_phys_top;
                n_state = alu_borrow ? S_BASE : S_RESP;
            end

            // offset from the base, must not be negative
            S_BASE: begin
                alu_b   = r_mem_base;
                n_off   = alu_sum[ADDR_W-1:0];
                n_state = alu_borrow ? S_RESP : S_RANGE;
            end

            // index must be below the page count; start the count read
            S_RANGE: begin
                alu_a   = r_off;
                alu_b   = PAGE_SPAN;
                n_state = alu_borrow ? S_EXEC : S_RESP;
            end

            // count read-modify-write and stack push
            S_EXEC: begin
                alu_a        = ADDR_W'(cnt_rdata);
                alu_b        = ADDR_W'(CNT_ONE);
                n_res_addr   = r_addr;
                n_res_status = STS_OK;
                n_state      = S_RESP;
                if (r_func == FUNC_FREE) begin
                    alu_sub = 1'b1;
                    cnt_we  = 1'b1;
                    if (cnt_rdata > CNT_ONE) begin
                        cnt_wdata   = alu_cnt;
                        n_res_count = CNT_OUT_W'(alu_cnt);
                    end else begin
                        // last reference gone, or a page handed in by software
                        cnt_wdata   = '0;
                        n_res_count = '0;
                        if (r_depth == DEPTH_W'(NUM_PAGES)) begin
                            n_res_status = STS_OVF;
                        end else begin
                            stk_we  = 1'b1;
                            n_depth = r_depth + 1'b1;
                        end
                    end
                end else begin
                    alu_sub = 1'b0;
                    if (cnt_rdata == CNT_MAX) begin
                        // saturated, count left as is
                        n_res_count  = CNT_OUT_W'(CNT_MAX);
                        n_res_status = STS_OVF;
                    end else begin
                        cnt_we      = 1'b1;
                        cnt_wdata   = alu_cnt;
                        n_res_count = CNT_OUT_W'(alu_cnt);
                    end
                end
            end

            // hand the result to the output register once it is free
            S_RESP: begin
                if (slot_free) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp_addr   = r_res_addr;
                    n_rsp_count  = r_res_count;
                    n_rsp_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.result_addr = r_rsp_addr;
    assign o_rsp.new_count   = r_rsp_count;
    assign o_rsp.status      = r_rsp_status;

endmodule

### design/pfa_checker.sv
// ----------------------------------------------------------------------------
// pfa_checker
// port-level checks of the page frame allocator, bound to the top level
// ----------------------------------------------------------------------------
module pfa_checker
    import pfa_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_req_valid,
    input logic                 i_req_ready,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input logic [ADDR_W-1:0]    i_rsp_addr,
    input logic [CNT_OUT_W-1:0] i_rsp_count,
    input logic [STATUS_W-1:0]  i_rsp_status
);

    // a stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_addr) && $stable(i_rsp_count)
            && $stable(i_rsp_status))
        else $error("response changed while stalled");

    // one request at a time: never ready just after taking a request
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // an empty allocate returns a null address and a zero count
    a_empty_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == STS_EMPTY |->
            i_rsp_addr == '0 && i_rsp_count == '0)
        else $error("empty response carries data");

    // a rejected address reports a zero count
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == STS_BAD |-> i_rsp_count == '0)
        else $error("bad address response carries a count");

endmodule

bind page_frame_allocator_refcount_unit pfa_checker u_pfa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_addr   (o_rsp.result_addr),
    .i_rsp_count  (o_rsp.new_count),
    .i_rsp_status (o_rsp.status)
);
